FILE: design/gncc_pkg.sv
package gncc_pkg;

	localparam int FACE_W  = 3;
	localparam int FIELD_W = 6;

	localparam int DEF_COMPONENT_WIDTH = 6;
	localparam int DEF_HALF_RANGE      = 32;
	localparam int DEF_GRADIENT_WIDTH  = 16;

	typedef enum logic [FACE_W-1:0] {
		FACE_NEG_X = 3'd0,
		FACE_NEG_Y = 3'd1,
		FACE_NEG_Z = 3'd2,
		FACE_POS_X = 3'd3,
		FACE_POS_Y = 3'd4,
		FACE_POS_Z = 3'd5,
		FACE_ZERO  = 3'd6
	} face_t;

endpackage

FILE: design/gncc_front.sv
module gncc_front #(
	parameter int GRADIENT_WIDTH = gncc_pkg::DEF_GRADIENT_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic signed [GRADIENT_WIDTH-1:0] grad_x,
	input  logic signed [GRADIENT_WIDTH-1:0] grad_y,
	input  logic signed [GRADIENT_WIDTH-1:0] grad_z,
	output logic                             out_valid,
	input  logic                             out_ready,
	output gncc_pkg::face_t                  out_face,
	output logic [GRADIENT_WIDTH-1:0]        out_mag,
	output logic [GRADIENT_WIDTH:0]          out_d1,
	output logic [GRADIENT_WIDTH:0]          out_d2
);
	import gncc_pkg::*;

	localparam int GW = GRADIENT_WIDTH;

	logic [GW-1:0] ax, ay, az;
	face_t         face;
	logic [GW-1:0] mag;
	logic [GW:0]   d1, d2;
	logic          v_s1;
	logic          take;

	assign ax = grad_x[GW-1] ? (~grad_x + 1'b1) : grad_x;
	assign ay = grad_y[GW-1] ? (~grad_y + 1'b1) : grad_y;
	assign az = grad_z[GW-1] ? (~grad_z + 1'b1) : grad_z;

	// strict compares: x wins ties over y, y over z
	always_comb begin
		logic signed [GW+1:0] mag_e;
		logic signed [GW+1:0] a_e, b_e;
		logic signed [GW+1:0] diff_a, diff_b;
		face = FACE_ZERO;
		mag  = '0;
		if (ax != '0) begin
			face = grad_x[GW-1] ? FACE_NEG_X : FACE_POS_X;
			mag  = ax;
		end
		if (ay > mag) begin
			face = grad_y[GW-1] ? FACE_NEG_Y : FACE_POS_Y;
			mag  = ay;
		end
		if (az > mag) begin
			face = grad_z[GW-1] ? FACE_NEG_Z : FACE_POS_Z;
			mag  = az;
		end
		a_e = '0;
		b_e = '0;
		unique case (face) inside
			FACE_NEG_X, FACE_POS_X: begin
				a_e = (GW+2)'(grad_y);
				b_e = (GW+2)'(grad_z);
			end
			FACE_NEG_Y, FACE_POS_Y: begin
				a_e = (GW+2)'(grad_x);
				b_e = (GW+2)'(grad_z);
			end
			FACE_NEG_Z, FACE_POS_Z: begin
				a_e = (GW+2)'(grad_x);
				b_e = (GW+2)'(grad_y);
			end
			default: begin
				a_e = '0;
				b_e = '0;
			end
		endcase
		mag_e  = signed'({2'b00, mag});
		// negated minor shifted onto [0, 2*mag]
		diff_a = mag_e - a_e;
		diff_b = mag_e - b_e;
		d1     = diff_a[GW:0];
		d2     = diff_b[GW:0];
	end

	assign full = v_s1 & ~out_ready;
	assign take = push & ~full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take | (v_s1 & ~out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_face <= face;
			out_mag  <= mag;
			out_d1   <= d1;
			out_d2   <= d2;
		end
	end

	assign out_valid = v_s1;

endmodule

FILE: design/gncc_queue.sv
module gncc_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	output logic         wr_ready,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_en,
	output logic [W-1:0] rd_data
);
	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         do_wr, do_rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign do_wr    = wr_en & wr_ready;
	assign do_rd    = rd_en & rd_valid;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= ~wr_ptr_q;
			if (do_rd) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

FILE: design/gncc_back.sv
module gncc_back #(
	parameter int GRADIENT_WIDTH  = gncc_pkg::DEF_GRADIENT_WIDTH,
	parameter int HALF_RANGE      = gncc_pkg::DEF_HALF_RANGE,
	parameter int COMPONENT_WIDTH = gncc_pkg::DEF_COMPONENT_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  gncc_pkg::face_t               in_face,
	input  logic [GRADIENT_WIDTH-1:0]     in_mag,
	input  logic [GRADIENT_WIDTH:0]       in_d1,
	input  logic [GRADIENT_WIDTH:0]       in_d2,
	output logic                          empty,
	input  logic                          pop,
	output logic [gncc_pkg::FACE_W-1:0]   cube_face,
	output logic [gncc_pkg::FIELD_W-1:0]  first_minor,
	output logic [gncc_pkg::FIELD_W-1:0]  second_minor
);
	import gncc_pkg::*;

	localparam int GW  = GRADIENT_WIDTH;
	localparam int QW  = $clog2(2*HALF_RANGE+1);
	localparam int HW  = $clog2(HALF_RANGE+1);
	localparam int NW  = GW + 1 + HW;
	localparam int WW  = (NW > GW + QW) ? NW : GW + QW;
	localparam logic [QW-1:0] Q_TOP = QW'(2*HALF_RANGE-1);
	localparam logic [FIELD_W-1:0] C_MASK = FIELD_W'((1 << COMPONENT_WIDTH) - 1);

	logic [NW-1:0] rem1_s [QW+1];
	logic [NW-1:0] rem2_s [QW+1];
	logic [QW-1:0] quo1_s [QW+1];
	logic [QW-1:0] quo2_s [QW+1];
	logic [GW-1:0] mag_s  [QW+1];
	face_t         face_s [QW+1];
	logic          v_s    [QW+1];
	logic          rdy    [QW+2];

	logic [NW-1:0] nrem1 [QW];
	logic [NW-1:0] nrem2 [QW];
	logic [QW-1:0] nquo1 [QW];
	logic [QW-1:0] nquo2 [QW];

	logic          res_v_q;
	logic [QW-1:0] q1_cl, q2_cl;

	// one quotient bit per stage, msb first
	always_comb begin
		logic [WW-1:0] dv;
		logic [WW-1:0] r1, r2;
		for (int k = 0; k < QW; k++) begin
			dv = WW'(mag_s[k]) << (QW-1-k);
			r1 = WW'(rem1_s[k]);
			r2 = WW'(rem2_s[k]);
			nrem1[k] = rem1_s[k];
			nrem2[k] = rem2_s[k];
			nquo1[k] = quo1_s[k];
			nquo2[k] = quo2_s[k];
			if (r1 >= dv) begin
				nrem1[k] = NW'(r1 - dv);
				nquo1[k] = quo1_s[k] | (QW'(1) << (QW-1-k));
			end
			if (r2 >= dv) begin
				nrem2[k] = NW'(r2 - dv);
				nquo2[k] = quo2_s[k] | (QW'(1) << (QW-1-k));
			end
		end
	end

	always_comb begin
		rdy[QW+1] = ~res_v_q | pop;
		for (int k = QW; k >= 0; k--) begin
			rdy[k] = ~v_s[k] | rdy[k+1];
		end
	end

	assign in_ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QW; k++) v_s[k] <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (rdy[0]) v_s[0] <= in_valid;
			for (int k = 1; k <= QW; k++) begin
				if (rdy[k]) v_s[k] <= v_s[k-1];
			end
			if (rdy[QW+1]) res_v_q <= v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			rem1_s[0] <= NW'(in_d1) * NW'(HALF_RANGE);
			rem2_s[0] <= NW'(in_d2) * NW'(HALF_RANGE);
			quo1_s[0] <= '0;
			quo2_s[0] <= '0;
			mag_s[0]  <= in_mag;
			face_s[0] <= in_face;
		end
		for (int k = 1; k <= QW; k++) begin
			if (rdy[k] && v_s[k-1]) begin
				rem1_s[k] <= nrem1[k-1];
				rem2_s[k] <= nrem2[k-1];
				quo1_s[k] <= nquo1[k-1];
				quo2_s[k] <= nquo2[k-1];
				mag_s[k]  <= mag_s[k-1];
				face_s[k] <= face_s[k-1];
			end
		end
	end

	// minor equal to minus the magnitude gives 2*half_range, clamp it
	assign q1_cl = (quo1_s[QW] > Q_TOP) ? Q_TOP : quo1_s[QW];
	assign q2_cl = (quo2_s[QW] > Q_TOP) ? Q_TOP : quo2_s[QW];

	always_ff @(posedge clk) begin
		if (rdy[QW+1] && v_s[QW]) begin
			cube_face <= face_s[QW];
			if (face_s[QW] == FACE_ZERO) begin
				first_minor  <= '0;
				second_minor <= '0;
			end else begin
				first_minor  <= FIELD_W'(q1_cl) & C_MASK;
				second_minor <= FIELD_W'(q2_cl) & C_MASK;
			end
		end
	end

	assign empty = ~res_v_q;

endmodule

FILE: design/gradient_normal_cube_code.sv
// channel  | handshake    | payload
// ---------+--------------+------------------------------------------
// input    | push / full  | grad_x, grad_y, grad_z (GRADIENT_WIDTH, signed)
// result   | pop / empty  | cube_face (3), first_minor (6), second_minor (6)
//
// one item per cycle sustained while pop keeps up; results come out in input order.
// an accepted item passes the front register, the queue, the divider stages
// and the result register before its result is visible; the divider is a
// restoring one, one quotient bit per stage.
// arst_n clears all valid state; the block then holds no items.
// a held result (pop low) stalls the divider stages, then the 2-entry
// queue, then the front register, and only then raises full.
module gradient_normal_cube_code #(
	parameter int COMPONENT_WIDTH = gncc_pkg::DEF_COMPONENT_WIDTH,
	parameter int HALF_RANGE      = gncc_pkg::DEF_HALF_RANGE,
	parameter int GRADIENT_WIDTH  = gncc_pkg::DEF_GRADIENT_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic signed [GRADIENT_WIDTH-1:0] grad_x,
	input  logic signed [GRADIENT_WIDTH-1:0] grad_y,
	input  logic signed [GRADIENT_WIDTH-1:0] grad_z,
	output logic                             empty,
	input  logic                             pop,
	output logic [gncc_pkg::FACE_W-1:0]      cube_face,
	output logic [gncc_pkg::FIELD_W-1:0]     first_minor,
	output logic [gncc_pkg::FIELD_W-1:0]     second_minor
);
	import gncc_pkg::*;

	localparam int GW = GRADIENT_WIDTH;
	localparam int PW = FACE_W + GW + 2*(GW+1);

	logic          f_valid, f_ready;
	face_t         f_face;
	logic [GW-1:0] f_mag;
	logic [GW:0]   f_d1, f_d2;

	logic          b_valid, b_ready;
	logic [PW-1:0] q_wdata, q_rdata;
	face_t         b_face;
	logic [GW-1:0] b_mag;
	logic [GW:0]   b_d1, b_d2;

	gncc_front #(
		.GRADIENT_WIDTH(GRADIENT_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.grad_x   (grad_x),
		.grad_y   (grad_y),
		.grad_z   (grad_z),
		.out_valid(f_valid),
		.out_ready(f_ready),
		.out_face (f_face),
		.out_mag  (f_mag),
		.out_d1   (f_d1),
		.out_d2   (f_d2)
	);

	assign q_wdata = {f_face, f_mag, f_d1, f_d2};

	gncc_queue #(
		.W(PW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_valid),
		.wr_ready(f_ready),
		.wr_data (q_wdata),
		.rd_valid(b_valid),
		.rd_en   (b_ready),
		.rd_data (q_rdata)
	);

	assign b_face = face_t'(q_rdata[PW-1 -: FACE_W]);
	assign b_mag  = q_rdata[2*(GW+1) +: GW];
	assign b_d1   = q_rdata[GW+1 +: GW+1];
	assign b_d2   = q_rdata[0 +: GW+1];

	gncc_back #(
		.GRADIENT_WIDTH (GRADIENT_WIDTH),
		.HALF_RANGE     (HALF_RANGE),
		.COMPONENT_WIDTH(COMPONENT_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (b_valid),
		.in_ready    (b_ready),
		.in_face     (b_face),
		.in_mag      (b_mag),
		.in_d1       (b_d1),
		.in_d2       (b_d2),
		.empty       (empty),
		.pop         (pop),
		.cube_face   (cube_face),
		.first_minor (first_minor),
		.second_minor(second_minor)
	);

endmodule

FILE: design/gncc_checker.sv
module gncc_checker #(
	parameter int HALF_RANGE = gncc_pkg::DEF_HALF_RANGE
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         push,
	input logic                         full,
	input logic                         empty,
	input logic                         pop,
	input logic [gncc_pkg::FACE_W-1:0]  cube_face,
	input logic [gncc_pkg::FIELD_W-1:0] first_minor,
	input logic [gncc_pkg::FIELD_W-1:0] second_minor
);
	import gncc_pkg::*;

	localparam int QW  = $clog2(2*HALF_RANGE+1);
	localparam int CAP = QW + 5;

	logic [7:0] cnt_q;
	logic       in_acc, out_acc;

	assign in_acc  = push & ~full;
	assign out_acc = pop & ~empty;

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + {7'd0, in_acc} - {7'd0, out_acc};
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(cube_face) && $stable(first_minor)
			&& $stable(second_minor))
		else $error("held item changed");

	a_zero_face: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && cube_face == FACE_ZERO |-> first_minor == '0 && second_minor == '0)
		else $error("zero gradient with nonzero minors");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> 7'(first_minor) <= 7'(2*HALF_RANGE-1)
			&& 7'(second_minor) <= 7'(2*HALF_RANGE-1) && cube_face <= FACE_ZERO)
		else $error("result out of range");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> empty)
		else $error("result with no item in flight");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 8'(CAP))
		else $error("more items in flight than storage");

endmodule

bind gradient_normal_cube_code gncc_checker #(
	.HALF_RANGE(HALF_RANGE)
) u_gncc_checker (.*);
